[src/asac_pkg.sv]
// ----------------------------------------------------------------------------
// asac_pkg
// Shared types and constants for the sensor average and convert unit.
// ----------------------------------------------------------------------------
`default_nettype none

package asac_pkg;

  localparam int CHANNELS    = 6;
  localparam int STORE_DEPTH = 7;
  localparam int DIV_STEPS   = 64;

  localparam logic [2:0] BATTERY_CH = 3'd6;

  localparam logic [2:0] REG_SPA   = 3'd0;
  localparam logic [2:0] REG_BITS  = 3'd1;
  localparam logic [2:0] REG_MASK  = 3'd2;
  localparam logic [2:0] REG_MODES = 3'd3;
  localparam logic [2:0] REG_CONV  = 3'd4;
  localparam logic [2:0] REG_WTEMP = 3'd5;

  localparam logic [2:0] MODE_RAW   = 3'd0;
  localparam logic [2:0] MODE_VOLT  = 3'd1;
  localparam logic [2:0] MODE_THERM = 3'd2;
  localparam logic [2:0] MODE_PH    = 3'd3;
  localparam logic [2:0] MODE_TURB  = 3'd4;
  localparam logic [2:0] MODE_EC    = 3'd5;
  localparam logic [2:0] MODE_TDS   = 3'd6;
  localparam logic [2:0] MODE_SAL   = 3'd7;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;

  localparam logic signed [65:0] VAL_MAX_W  = 66'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] VAL_MIN_W  = -66'sh0_8000_0000_0000;
  localparam logic signed [65:0] KELVIN_Q16 = 66'sd17901158;
  localparam logic [29:0]        LN2_Q30    = 30'd744261118;
  localparam logic [63:0]        THERM_NUM  = 64'd117769250 << 36;
  localparam logic signed [63:0] THERM_D0   = 64'sd414187520000;
  localparam logic signed [63:0] HORNER_C0  = 64'sd1676804096;
  localparam logic signed [63:0] HORNER_C1  = 64'sd5618991104;

  typedef enum logic [2:0] {
    K_RAW, K_VOLT, K_THERM, K_PH, K_EC, K_TDS, K_SAL, K_BATT
  } kind_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_START, BK_VDIV, BK_MSTART, BK_MUL, BK_MRES, BK_EDIV,
    BK_LOG_INIT, BK_LOG_ITER, BK_LOG_END, BK_LN, BK_DEN, BK_TDIV,
    BK_FDIV, BK_FIN, BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic [7:0]         spa;
    logic [4:0]         adc_bits;
    logic [5:0]         en_mask;
    logic [17:0]        modes;
    logic               conv_on;
    logic signed [14:0] wtemp;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  ch;
    logic [15:0] avg;
    kind_t       kind;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [40:0] den;
  } div_req_t;

endpackage

`default_nettype wire

[src/asac_div.sv]
// ----------------------------------------------------------------------------
// asac_div
// Shared radix-2 divider giving the quotient rounded half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire asac_pkg::div_req_t req,
  output logic                    done,
  output logic [63:0]             quo
);

  logic [63:0] quo_r;
  logic [40:0] rem_r;
  logic [40:0] den_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [41:0] rem_sh;
  logic [41:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem_r, quo_r[63]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= 7'(asac_pkg::DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num + {23'b0, req.den >> 1};
      rem_r <= '0;
      den_r <= req.den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? rem_sub[40:0] : rem_sh[40:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

[src/asac_fifo.sv]
// ----------------------------------------------------------------------------
// asac_fifo
// Two-entry queue of completed averages between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire asac_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output asac_pkg::job_t      head
);

  asac_pkg::job_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign full  = count_r == 2'd2;
  assign valid = count_r != 2'd0;
  assign head  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

[src/asac_front.sv]
// ----------------------------------------------------------------------------
// asac_front
// Per-channel accumulation, averaging shift and conversion classification.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire asac_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [2:0]     in_ch,
  input  wire logic [15:0]    in_sample,
  input  wire logic           q_full,
  output logic                push,
  output asac_pkg::job_t      job
);

  logic [23:0] sum_r [asac_pkg::STORE_DEPTH];
  logic [7:0]  cnt_r [asac_pkg::STORE_DEPTH];

  logic        accept;
  logic        keep;
  logic        complete;
  logic [7:0]  need;
  logic [23:0] sum_new;
  logic [7:0]  cnt_new;
  logic [23:0] shifted;
  logic [2:0]  mode;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    keep = 1'b0;
    if (in_ch == asac_pkg::BATTERY_CH) begin
      keep = 1'b1;
    end else if (in_ch < 3'(asac_pkg::CHANNELS)) begin
      keep = cfg.en_mask[in_ch];
    end
  end

  assign need     = (cfg.spa == 8'd0) ? 8'd1 : cfg.spa;
  assign sum_new  = sum_r[in_ch] + {8'b0, in_sample};
  assign cnt_new  = cnt_r[in_ch] + 8'd1;
  assign complete = cnt_new >= need;

  always_comb begin
    case (need)
      8'd2:    shifted = sum_new >> 1;
      8'd4:    shifted = sum_new >> 2;
      8'd8:    shifted = sum_new >> 3;
      8'd16:   shifted = sum_new >> 4;
      default: shifted = sum_new;
    endcase
  end

  always_comb begin
    case (in_ch)
      3'd0:    mode = cfg.modes[2:0];
      3'd1:    mode = cfg.modes[5:3];
      3'd2:    mode = cfg.modes[8:6];
      3'd3:    mode = cfg.modes[11:9];
      3'd4:    mode = cfg.modes[14:12];
      3'd5:    mode = cfg.modes[17:15];
      default: mode = asac_pkg::MODE_RAW;
    endcase
    if (!cfg.conv_on) begin
      mode = asac_pkg::MODE_RAW;
    end
  end

  always_comb begin
    job.ch  = in_ch;
    job.avg = shifted[15:0];
    if (in_ch == asac_pkg::BATTERY_CH) begin
      job.kind = asac_pkg::K_BATT;
    end else begin
      case (mode)
        asac_pkg::MODE_VOLT:  job.kind = asac_pkg::K_VOLT;
        asac_pkg::MODE_THERM: job.kind = asac_pkg::K_THERM;
        asac_pkg::MODE_PH:    job.kind = asac_pkg::K_PH;
        asac_pkg::MODE_EC:    job.kind = asac_pkg::K_EC;
        asac_pkg::MODE_TDS:   job.kind = asac_pkg::K_TDS;
        asac_pkg::MODE_SAL:   job.kind = asac_pkg::K_SAL;
        default:              job.kind = asac_pkg::K_RAW;
      endcase
    end
  end

  assign push = accept && keep && complete;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < asac_pkg::STORE_DEPTH; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (accept && keep) begin
      sum_r[in_ch] <= complete ? 24'd0 : sum_new;
      cnt_r[in_ch] <= complete ? 8'd0 : cnt_new;
    end
  end

endmodule

`default_nettype wire

[src/asac_back.sv]
// ----------------------------------------------------------------------------
// asac_back
// Sequencer that converts one average per request into a Q32.16 value.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire asac_pkg::cfg_t cfg,
  input  wire logic           job_valid,
  input  wire asac_pkg::job_t job,
  output logic                job_pop,
  output asac_pkg::div_req_t  div_req,
  input  wire logic           div_done,
  input  wire logic [63:0]    div_quo,
  output logic                out_valid,
  output logic [2:0]          out_ch,
  output logic [15:0]         out_avg,
  output logic [47:0]         out_val,
  output logic [1:0]          out_st,
  input  wire logic           out_ready
);

  asac_pkg::bk_state_t state_r, state_nxt;
  asac_pkg::job_t      job_r;

  logic [47:0]        val_r;
  logic [1:0]         st_r;
  logic               neg_r;
  logic               pass_r;
  logic signed [63:0] u_r;
  logic [24:0]        vq_r;
  logic [63:0]        mul_m_r;
  logic [88:0]        mul_acc_r;
  logic [4:0]         cnt_r;
  logic [31:0]        logm_r;
  logic [4:0]         loge_r;
  logic [27:0]        frac_r;
  logic [32:0]        logn_r;
  logic               out_valid_r;
  logic [2:0]         out_ch_r;
  logic [15:0]        out_avg_r;
  logic [47:0]        out_val_r;
  logic [1:0]         out_st_r;

  logic [63:0]        avg64;
  logic [40:0]        vden;
  logic [40:0]        pden;
  logic signed [15:0] cden;
  logic [15:0]        cden_abs;
  logic [15:0]        sal_abs;
  logic [63:0]        u_abs;
  logic [23:0]        log_x;
  logic [4:0]         log_e;
  logic [31:0]        logm_init;
  logic [63:0]        sq;
  logic [31:0]        m2;
  logic signed [33:0] ldiff;
  logic [63:0]        lm_sum;
  logic [40:0]        pp;
  logic [63:0]        mres;
  logic signed [63:0] mres_s;
  logic signed [63:0] u1;
  logic signed [65:0] fin_s;
  logic signed [65:0] fin_k;
  logic               can_out;

  assign avg64    = {48'b0, job_r.avg};
  assign vden     = 41'd10 << cfg.adc_bits;
  assign pden     = 41'd100 << cfg.adc_bits;
  assign cden     = $signed({cfg.wtemp[14], cfg.wtemp}) + 16'sd2500;
  assign cden_abs = cden[15] ? 16'(-cden) : 16'(cden);
  assign sal_abs  = (job_r.avg < 16'd76) ? (16'd76 - job_r.avg) : (job_r.avg - 16'd76);
  assign u_abs    = u_r[63] ? $unsigned(-u_r) : $unsigned(u_r);

  always_comb begin
    log_x = pass_r ? (24'd1000 * {12'b0, job_r.avg[11:0]})
                   : (24'd2933 * {12'b0, 12'(12'd4095 - job_r.avg[11:0])});
    log_e = '0;
    for (int i = 0; i < 24; i++) begin
      if (log_x[i]) begin
        log_e = 5'(i);
      end
    end
  end

  assign logm_init = {8'b0, log_x} << (5'd30 - log_e);
  assign sq        = 64'(logm_r) * 64'(logm_r);
  assign m2        = sq[61:30];
  assign ldiff     = $signed({1'b0, logn_r}) - $signed({1'b0, loge_r, frac_r});
  assign lm_sum    = 64'(u_abs[32:0]) * 64'(asac_pkg::LN2_Q30) + (64'd1 << 37);

  assign pp     = {25'b0, mul_m_r[63:48]} * {16'b0, vq_r};
  assign mres   = 64'((mul_acc_r + 89'd32768) >> 16);
  assign mres_s = u_r[63] ? -$signed(mres) : $signed(mres);
  assign u1     = $signed({39'b0, div_quo[24:0]}) * 64'sd13342 - asac_pkg::HORNER_C0;

  assign fin_s = neg_r ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
  assign fin_k = (job_r.kind == asac_pkg::K_THERM) ? fin_s - asac_pkg::KELVIN_Q16 : fin_s;

  assign can_out = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asac_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    div_req   = '0;
    case (state_r)
      asac_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          state_nxt = asac_pkg::BK_START;
        end
      end
      asac_pkg::BK_START: begin
        case (job_r.kind)
          asac_pkg::K_VOLT: begin
            div_req   = '{1'b1, avg64 * 64'd2162688, vden};
            state_nxt = asac_pkg::BK_FDIV;
          end
          asac_pkg::K_BATT: begin
            div_req   = '{1'b1, avg64 * 64'd4325376, vden};
            state_nxt = asac_pkg::BK_FDIV;
          end
          asac_pkg::K_PH: begin
            div_req   = '{1'b1, avg64 * 64'd75694080, pden};
            state_nxt = asac_pkg::BK_FDIV;
          end
          asac_pkg::K_SAL: begin
            div_req   = '{1'b1, {48'b0, sal_abs} * 64'd40960000, 41'd58};
            state_nxt = asac_pkg::BK_FDIV;
          end
          asac_pkg::K_EC, asac_pkg::K_TDS: begin
            div_req   = '{1'b1, avg64 * 64'd2162688, vden};
            state_nxt = asac_pkg::BK_VDIV;
          end
          asac_pkg::K_THERM: begin
            if (job_r.avg == 16'd0 || job_r.avg >= 16'd4095) begin
              state_nxt = asac_pkg::BK_OUT;
            end else begin
              state_nxt = asac_pkg::BK_LOG_INIT;
            end
          end
          default: state_nxt = asac_pkg::BK_OUT;
        endcase
      end
      asac_pkg::BK_VDIV: begin
        if (div_done) begin
          if (cden == 16'sd0 || div_quo[63:25] != '0) begin
            state_nxt = asac_pkg::BK_OUT;
          end else begin
            state_nxt = asac_pkg::BK_MSTART;
          end
        end
      end
      asac_pkg::BK_MSTART: state_nxt = asac_pkg::BK_MUL;
      asac_pkg::BK_MUL: begin
        if (cnt_r == 5'd0) begin
          state_nxt = asac_pkg::BK_MRES;
        end
      end
      asac_pkg::BK_MRES: state_nxt = pass_r ? asac_pkg::BK_EDIV : asac_pkg::BK_MSTART;
      asac_pkg::BK_EDIV: begin
        div_req.start = 1'b1;
        div_req.num   = u_abs * ((job_r.kind == asac_pkg::K_EC) ? 64'd50 : 64'd25);
        div_req.den   = {25'b0, cden_abs};
        state_nxt     = asac_pkg::BK_FDIV;
      end
      asac_pkg::BK_LOG_INIT: state_nxt = asac_pkg::BK_LOG_ITER;
      asac_pkg::BK_LOG_ITER: begin
        if (cnt_r == 5'd0) begin
          state_nxt = asac_pkg::BK_LOG_END;
        end
      end
      asac_pkg::BK_LOG_END: state_nxt = pass_r ? asac_pkg::BK_LN : asac_pkg::BK_LOG_INIT;
      asac_pkg::BK_LN:      state_nxt = asac_pkg::BK_DEN;
      asac_pkg::BK_DEN:     state_nxt = asac_pkg::BK_TDIV;
      asac_pkg::BK_TDIV: begin
        if (u_r == 64'sd0) begin
          state_nxt = asac_pkg::BK_OUT;
        end else begin
          div_req   = '{1'b1, asac_pkg::THERM_NUM, u_abs[40:0]};
          state_nxt = asac_pkg::BK_FDIV;
        end
      end
      asac_pkg::BK_FDIV: begin
        if (div_done) begin
          state_nxt = asac_pkg::BK_FIN;
        end
      end
      asac_pkg::BK_FIN: state_nxt = asac_pkg::BK_OUT;
      asac_pkg::BK_OUT: begin
        if (can_out) begin
          state_nxt = asac_pkg::BK_IDLE;
        end
      end
      default: state_nxt = asac_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      asac_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_r  <= job;
          st_r   <= asac_pkg::ST_OK;
          val_r  <= '0;
          neg_r  <= 1'b0;
          pass_r <= 1'b0;
        end
      end
      asac_pkg::BK_START: begin
        case (job_r.kind)
          asac_pkg::K_RAW: val_r <= {16'b0, job_r.avg, 16'b0};
          asac_pkg::K_SAL: neg_r <= job_r.avg < 16'd76;
          asac_pkg::K_THERM: begin
            if (job_r.avg == 16'd0) begin
              st_r <= asac_pkg::ST_DIV;
            end else if (job_r.avg >= 16'd4095) begin
              st_r <= asac_pkg::ST_SAT;
            end
          end
          default: ;
        endcase
      end
      asac_pkg::BK_VDIV: begin
        if (div_done) begin
          vq_r <= div_quo[24:0];
          if (cden == 16'sd0) begin
            st_r <= asac_pkg::ST_DIV;
          end else if (div_quo[63:25] != '0) begin
            st_r  <= asac_pkg::ST_SAT;
            val_r <= cden[15] ? asac_pkg::VAL_MIN_W[47:0] : asac_pkg::VAL_MAX_W[47:0];
          end else begin
            u_r <= u1;
          end
        end
      end
      asac_pkg::BK_MSTART: begin
        mul_m_r   <= u_abs;
        mul_acc_r <= '0;
        cnt_r     <= 5'd3;
      end
      asac_pkg::BK_MUL: begin
        mul_acc_r <= (mul_acc_r << 16) + 89'(pp);
        mul_m_r   <= mul_m_r << 16;
        cnt_r     <= cnt_r - 5'd1;
      end
      asac_pkg::BK_MRES: begin
        u_r    <= pass_r ? mres_s : mres_s + asac_pkg::HORNER_C1;
        pass_r <= 1'b1;
      end
      asac_pkg::BK_EDIV: neg_r <= u_r[63] ^ cden[15];
      asac_pkg::BK_LOG_INIT: begin
        logm_r <= logm_init;
        loge_r <= log_e;
        cnt_r  <= 5'd27;
      end
      asac_pkg::BK_LOG_ITER: begin
        logm_r <= m2[31] ? (m2 >> 1) : m2;
        frac_r <= {frac_r[26:0], m2[31]};
        cnt_r  <= cnt_r - 5'd1;
      end
      asac_pkg::BK_LOG_END: begin
        if (!pass_r) begin
          logn_r <= {loge_r, frac_r};
          pass_r <= 1'b1;
        end else begin
          u_r <= 64'(ldiff);
        end
      end
      asac_pkg::BK_LN: begin
        u_r <= u_r[63] ? -$signed({38'b0, lm_sum[63:38]}) : $signed({38'b0, lm_sum[63:38]});
      end
      asac_pkg::BK_DEN: u_r <= u_r * 64'sd29815 + asac_pkg::THERM_D0;
      asac_pkg::BK_TDIV: begin
        if (u_r == 64'sd0) begin
          st_r <= asac_pkg::ST_DIV;
        end else begin
          neg_r <= u_r[63];
        end
      end
      asac_pkg::BK_FIN: begin
        if (fin_k > asac_pkg::VAL_MAX_W) begin
          val_r <= asac_pkg::VAL_MAX_W[47:0];
          st_r  <= asac_pkg::ST_SAT;
        end else if (fin_k < asac_pkg::VAL_MIN_W) begin
          val_r <= asac_pkg::VAL_MIN_W[47:0];
          st_r  <= asac_pkg::ST_SAT;
        end else begin
          val_r <= fin_k[47:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == asac_pkg::BK_OUT && can_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == asac_pkg::BK_OUT && can_out) begin
      out_ch_r  <= job_r.ch;
      out_avg_r <= job_r.avg;
      out_val_r <= val_r;
      out_st_r  <= st_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_avg   = out_avg_r;
  assign out_val   = out_val_r;
  assign out_st    = out_st_r;

endmodule

`default_nettype wire

[src/analog_sensor_average_convert_unit.sv]
// ----------------------------------------------------------------------------
// analog_sensor_average_convert_unit
// Throughput: one request per cycle while the completed-average queue is not
// full; completed averages are converted one at a time, the divide-based
// modes on the shared 64-step divider.
// Synchronous reset clears all sums and counts and restores the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module analog_sensor_average_convert_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // sample
  input  wire logic [2:0]  in_tuser,   // channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // average, value, status
  output logic [2:0]       out_tuser,  // out_channel
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  asac_pkg::cfg_t     cfg_r;
  asac_pkg::job_t     f_job;
  asac_pkg::job_t     q_head;
  asac_pkg::div_req_t div_req;

  logic        f_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        div_done;
  logic [63:0] div_quo;
  logic [47:0] out_val;
  logic [15:0] out_avg;
  logic [1:0]  out_st;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spa      <= 8'd1;
      cfg_r.adc_bits <= 5'd12;
      cfg_r.en_mask  <= '0;
      cfg_r.modes    <= '0;
      cfg_r.conv_on  <= 1'b1;
      cfg_r.wtemp    <= 15'sd2500;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        asac_pkg::REG_SPA:   cfg_r.spa      <= pwdata[7:0];
        asac_pkg::REG_BITS:  cfg_r.adc_bits <= pwdata[4:0];
        asac_pkg::REG_MASK:  cfg_r.en_mask  <= pwdata[5:0];
        asac_pkg::REG_MODES: cfg_r.modes    <= pwdata[17:0];
        asac_pkg::REG_CONV:  cfg_r.conv_on  <= pwdata[0];
        asac_pkg::REG_WTEMP: cfg_r.wtemp    <= $signed(pwdata[14:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      asac_pkg::REG_SPA:   prdata = {24'b0, cfg_r.spa};
      asac_pkg::REG_BITS:  prdata = {27'b0, cfg_r.adc_bits};
      asac_pkg::REG_MASK:  prdata = {26'b0, cfg_r.en_mask};
      asac_pkg::REG_MODES: prdata = {14'b0, cfg_r.modes};
      asac_pkg::REG_CONV:  prdata = {31'b0, cfg_r.conv_on};
      asac_pkg::REG_WTEMP: prdata = {17'b0, cfg_r.wtemp};
      default:             prdata = '0;
    endcase
  end

  asac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ch     (in_tuser),
    .in_sample (in_tdata),
    .q_full    (q_full),
    .push      (f_push),
    .job       (f_job)
  );

  asac_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_job (f_job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  asac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  asac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job       (q_head),
    .job_pop   (q_pop),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_quo   (div_quo),
    .out_valid (out_tvalid),
    .out_ch    (out_tuser),
    .out_avg   (out_avg),
    .out_val   (out_val),
    .out_st    (out_st),
    .out_ready (out_tready)
  );

  assign out_tdata = {6'b0, out_st, out_val, out_avg};

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] != 2'd3)
    else $error("undefined status code on output");

  a_div_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] == asac_pkg::ST_DIV |-> out_tdata[63:16] == 48'd0)
    else $error("divide-by-zero result carries a nonzero value");

  a_no_absent_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 3'd7)
    else $error("result reported for an absent channel");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> !q_full)
    else $error("completed average pushed into a full queue");

endmodule

`default_nettype wire
